>>> src/mtem_pkg.sv
// Package for the multi-timer expiry manager.
// Timer count, op codes, entry record, FSM states and RAM control struct.
// No dependencies.
`default_nettype none
package mtem_pkg;
  localparam int TIMERS = 16;
  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W = $clog2(TIMERS + 1);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] period;
    logic        periodic;
    logic [31:0] tag;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FIRE,
    ST_MINS
  } state_t;
endpackage
`default_nettype wire

>>> src/mtem_in_if.sv
// Command channel of the timer manager: valid/ready and the command beat.
// Depends on nothing.
`default_nettype none
interface mtem_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  timer_index;
  logic [31:0] now_time;
  logic [31:0] interval;
  logic        repeat_req;
  logic [31:0] user_tag;
  modport source(output valid, op, timer_index, now_time, interval, repeat_req, user_tag,
                 input ready);
  modport sink(input valid, op, timer_index, now_time, interval, repeat_req, user_tag,
               output ready);
endinterface
`default_nettype wire

>>> src/mtem_out_if.sv
// Result channel of the timer manager: valid/ready and the result beat.
// Depends on nothing.
`default_nettype none
interface mtem_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  fired_index;
  logic [31:0] fired_tag;
  logic        status;
  logic [31:0] next_delay;
  logic        last;
  modport source(output valid, kind, fired_index, fired_tag, status, next_delay, last,
                 input ready);
  modport sink(input valid, kind, fired_index, fired_tag, status, next_delay, last,
               output ready);
endinterface
`default_nettype wire

>>> src/mtem_ram.sv
// Timer entry store: one write port, one read port, registered read data.
// Depends on mtem_pkg.
`default_nettype none
module mtem_ram
  import mtem_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_ctl_t ctl,
  output entry_t        rdata
);
  entry_t mem [TIMERS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rdata <= mem[ctl.raddr];
  end
endmodule
`default_nettype wire

>>> src/multi_timer_expiry_manager.sv
// Multi-timer expiry manager: up to TIMERS one-shot or periodic timers on a wrapping
// 32-bit time base. Start and stop each give one completion beat. A tick works through
// the entry RAM in sweeps, one entry read per cycle: a sweep marks due timers, then one
// sweep per expiry finds the earliest pending timer, then a final sweep finds the next
// deadline. When time has wrapped, the armed timers whose deadlines had not wrapped
// fire first, earliest first. Commands are taken only while no tick is in progress.
// Depends on mtem_pkg, mtem_in_if, mtem_out_if, mtem_ram.
`default_nettype none
module multi_timer_expiry_manager
  import mtem_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  mtem_in_if.sink   cmd,
  mtem_out_if.source rsp
);
  state_t state, state_next;

  logic [TIMERS-1:0] armed, ovf, pend;
  logic [31:0]       nowr, prev;
  logic              wrapph;
  logic [CNT_W-1:0]  cnt;
  logic              rv;
  logic [IDX_W-1:0]  ridx;
  logic              bf;
  logic [IDX_W-1:0]  bidx;
  entry_t            bent;
  entry_t            rdata;
  ram_ctl_t          ctl;

  logic              ov;
  logic              o_kind, o_status, o_last;
  logic [3:0]        o_idx;
  logic [31:0]       o_tag, o_delay;

  logic              out_free, acc, sdone, cnt_run, idx_ok, emit;
  logic [IDX_W-1:0]  cidx;
  logic [31:0]       sum_start, sum_fire;

  assign out_free  = !ov || rsp.ready;
  assign acc       = cmd.valid && cmd.ready;
  assign cnt_run   = cnt < CNT_W'(TIMERS);
  assign sdone     = !cnt_run && !rv;
  assign idx_ok    = 32'(cmd.timer_index) < TIMERS;
  assign cidx      = IDX_W'(cmd.timer_index);
  assign sum_start = cmd.now_time + cmd.interval;
  assign sum_fire  = nowr + bent.period;
  assign emit      = (state == ST_IDLE && acc && cmd.op != OP_TICK) ||
                     (state == ST_FIRE && out_free) ||
                     (state == ST_MINS && sdone && out_free);

  mtem_ram u_ram (.clk(clk), .ctl(ctl), .rdata(rdata));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && cmd.op == OP_TICK) begin
          state_next = (cmd.now_time < prev) ? ST_SCAN : ST_PREP;
        end
      end
      ST_PREP: if (sdone) state_next = ST_SCAN;
      ST_SCAN: begin
        if (sdone) begin
          if (bf) state_next = ST_FIRE;
          else if (wrapph) state_next = ST_PREP;
          else state_next = ST_MINS;
        end
      end
      ST_FIRE: if (out_free) state_next = ST_SCAN;
      ST_MINS: if (sdone && out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready   = (state == ST_IDLE) && out_free;
    ctl.raddr   = cnt[IDX_W-1:0];
    ctl.we      = 1'b0;
    ctl.waddr   = cidx;
    ctl.wdata   = '{deadline: sum_start, period: cmd.interval,
                    periodic: cmd.repeat_req, tag: cmd.user_tag};
    case (state)
      ST_IDLE: ctl.we = acc && cmd.op == OP_START && idx_ok && !armed[cidx];
      ST_FIRE: begin
        ctl.we    = out_free && bent.periodic;
        ctl.waddr = bidx;
        ctl.wdata = '{deadline: sum_fire, period: bent.period,
                      periodic: bent.periodic, tag: bent.tag};
      end
      default: ctl.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      armed  <= '0;
      ovf    <= '0;
      pend   <= '0;
      prev   <= '0;
      wrapph <= 1'b0;
      cnt    <= '0;
      rv     <= 1'b0;
      bf     <= 1'b0;
      ov     <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;
      if (state == ST_PREP || state == ST_SCAN || state == ST_MINS) begin
        rv   <= cnt_run;
        ridx <= cnt[IDX_W-1:0];
        if (cnt_run) cnt <= cnt + 1'b1;
      end
      if (rv) begin
        case (state)
          ST_PREP: pend[ridx] <= armed[ridx] && !ovf[ridx] && rdata.deadline <= nowr;
          ST_SCAN: begin
            if (pend[ridx] && (!bf || rdata.deadline < bent.deadline)) begin
              bf <= 1'b1; bidx <= ridx; bent <= rdata;
            end
          end
          ST_MINS: begin
            if (armed[ridx] && !ovf[ridx] && (!bf || rdata.deadline < bent.deadline)) begin
              bf <= 1'b1; bent <= rdata;
            end
          end
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            o_kind <= KIND_DONE; o_idx <= cmd.timer_index; o_tag <= '0;
            o_delay <= '0; o_last <= 1'b1;
            cnt <= '0; rv <= 1'b0; bf <= 1'b0; nowr <= cmd.now_time;
            case (cmd.op)
              OP_START: begin
                o_status <= !(idx_ok && !armed[cidx]);
                if (idx_ok && !armed[cidx]) begin
                  armed[cidx] <= 1'b1;
                  ovf[cidx]   <= sum_start < cmd.now_time;
                end
              end
              OP_STOP: begin
                o_status <= !(idx_ok && armed[cidx]);
                if (idx_ok && armed[cidx]) begin
                  armed[cidx] <= 1'b0;
                  ovf[cidx]   <= 1'b0;
                end
              end
              OP_TICK: begin
                o_status <= 1'b1;
                wrapph <= cmd.now_time < prev;
                if (cmd.now_time < prev) pend <= armed & ~ovf;
              end
              default: o_status <= 1'b1;
            endcase
          end
        end
        ST_PREP: if (sdone) begin cnt <= '0; bf <= 1'b0; end
        ST_SCAN: begin
          if (sdone && !bf) begin
            cnt <= '0;
            if (wrapph) begin
              wrapph <= 1'b0;
              ovf    <= '0;
            end
          end
        end
        ST_FIRE: begin
          if (out_free) begin
            o_kind <= KIND_EXPIRY; o_idx <= 4'(bidx); o_tag <= bent.tag;
            o_status <= 1'b0; o_delay <= '0; o_last <= 1'b0;
            pend[bidx] <= 1'b0;
            if (bent.periodic) begin
              ovf[bidx] <= wrapph || sum_fire < nowr;
            end else begin
              armed[bidx] <= 1'b0;
              ovf[bidx]   <= 1'b0;
            end
            cnt <= '0; rv <= 1'b0; bf <= 1'b0;
          end
        end
        ST_MINS: begin
          if (sdone && out_free) begin
            o_kind <= KIND_DONE; o_idx <= '0; o_tag <= '0; o_status <= 1'b0;
            o_delay <= (bf ? bent.deadline : 32'hFFFF_FFFF) - nowr; o_last <= 1'b1;
            prev <= nowr;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid       = ov;
  assign rsp.kind        = o_kind;
  assign rsp.fired_index = o_idx;
  assign rsp.fired_tag   = o_tag;
  assign rsp.status      = o_status;
  assign rsp.next_delay  = o_delay;
  assign rsp.last        = o_last;

  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> pend == '0) else $error("pending set outside a tick");
  a_pend_armed: assert property (@(posedge clk) disable iff (rst)
    (pend & ~armed) == '0) else $error("pending timer not armed");
  a_fire_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIRE |-> bf) else $error("fire without a chosen timer");
  a_no_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !cmd.ready) else $error("command taken during a tick");
endmodule
`default_nettype wire

>>> tb/timer_checker.sv
// Checker for the timer manager: watches both channels, predicts the results of each
// accepted command beat and compares every result beat against them.
// Depends on mtem_pkg, mtem_in_if, mtem_out_if.
`timescale 1ns / 1ps
module timer_checker
  import mtem_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mtem_in_if   cmd,
  mtem_out_if  rsp,
  output int   errors,
  output int   pending
);
  typedef struct packed {
    logic        kind;
    logic [3:0]  idx;
    logic [31:0] tag;
    logic        status;
    logic [31:0] delay;
    logic        last;
  } result_t;

  result_t     expected_q[$];
  bit          armed[TIMERS];
  bit          parked[TIMERS];
  logic [31:0] due_at[TIMERS];
  logic [31:0] period[TIMERS];
  bit          periodic[TIMERS];
  logic [31:0] tag_of[TIMERS];
  logic [31:0] last_now;

  initial pending = 0;

  function automatic result_t mk(logic kind, logic [3:0] idx, logic [31:0] tag,
                                 logic status, logic [31:0] delay, logic last);
    result_t r;
    r.kind = kind; r.idx = idx; r.tag = tag;
    r.status = status; r.delay = delay; r.last = last;
    return r;
  endfunction

  function automatic void fire_sweep(logic [31:0] now, bit wrap);
    bit sel[TIMERS];
    int best;
    for (int i = 0; i < TIMERS; i++)
      sel[i] = armed[i] && !parked[i] && (wrap || due_at[i] <= now);
    forever begin
      best = -1;
      for (int i = 0; i < TIMERS; i++)
        if (sel[i] && (best < 0 || due_at[i] < due_at[best])) best = i;
      if (best < 0) break;
      sel[best] = 0;
      expected_q.push_back(mk(KIND_EXPIRY, best[3:0], tag_of[best], 1'b0, '0, 1'b0));
      if (periodic[best]) begin
        due_at[best] = now + period[best];
        parked[best] = wrap || (due_at[best] < now);
      end else begin
        armed[best] = 0;
        parked[best] = 0;
      end
    end
  endfunction

  function automatic void predict(logic [1:0] op, logic [3:0] idx, logic [31:0] now,
                                  logic [31:0] ivl, logic rep, logic [31:0] tag);
    logic        st;
    logic [31:0] best;
    bit          found;
    st = 1'b1;
    found = 0;
    best = '1;
    case (op)
      OP_START: begin
        if (idx < TIMERS && !armed[idx]) begin
          due_at[idx] = now + ivl;
          period[idx] = ivl;
          periodic[idx] = rep;
          tag_of[idx] = tag;
          parked[idx] = (now + ivl) < now;
          armed[idx] = 1;
          st = 1'b0;
        end
        expected_q.push_back(mk(KIND_DONE, idx, '0, st, '0, 1'b1));
      end
      OP_STOP: begin
        if (idx < TIMERS && armed[idx]) begin
          armed[idx] = 0;
          parked[idx] = 0;
          st = 1'b0;
        end
        expected_q.push_back(mk(KIND_DONE, idx, '0, st, '0, 1'b1));
      end
      OP_TICK: begin
        if (now < last_now) begin
          fire_sweep(now, 1);
          for (int i = 0; i < TIMERS; i++) parked[i] = 0;
        end
        fire_sweep(now, 0);
        last_now = now;
        for (int i = 0; i < TIMERS; i++)
          if (armed[i] && !parked[i] && (!found || due_at[i] < best)) begin
            best = due_at[i];
            found = 1;
          end
        expected_q.push_back(mk(KIND_DONE, 4'd0, '0, 1'b0, best - now, 1'b1));
      end
      default: expected_q.push_back(mk(KIND_DONE, idx, '0, 1'b1, '0, 1'b1));
    endcase
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      expected_q.delete();
      for (int i = 0; i < TIMERS; i++) begin
        armed[i] = 0;
        parked[i] = 0;
      end
      last_now = '0;
      errors = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (rsp.kind !== e.kind) begin
            $error("kind: expected %0h, got %0h", e.kind, rsp.kind); errors++;
          end
          if (rsp.fired_index !== e.idx) begin
            $error("fired_index: expected %0h, got %0h", e.idx, rsp.fired_index); errors++;
          end
          if (rsp.fired_tag !== e.tag) begin
            $error("fired_tag: expected %0h, got %0h", e.tag, rsp.fired_tag); errors++;
          end
          if (rsp.status !== e.status) begin
            $error("status: expected %0h, got %0h", e.status, rsp.status); errors++;
          end
          if (rsp.next_delay !== e.delay) begin
            $error("next_delay: expected %0h, got %0h", e.delay, rsp.next_delay); errors++;
          end
          if (rsp.last !== e.last) begin
            $error("last: expected %0h, got %0h", e.last, rsp.last); errors++;
          end
        end
      end
      if (cmd.valid && cmd.ready)
        predict(cmd.op, cmd.timer_index, cmd.now_time, cmd.interval, cmd.repeat_req,
                cmd.user_tag);
    end
    pending = expected_q.size();
  end
endmodule

>>> tb/testbench.sv
// Top of the timer manager testbench: clock, reset, command stimulus and result-side
// backpressure; the checker instance does all prediction and comparison.
// Depends on mtem_pkg, mtem_in_if, mtem_out_if, multi_timer_expiry_manager, timer_checker.
`timescale 1ns / 1ps
module testbench;
  import mtem_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending;
  bit   hold_long = 0;
  bit   stim_done = 0;
  logic [31:0] cur_time = 32'd1000;

  mtem_in_if  cmd();
  mtem_out_if rsp();

  multi_timer_expiry_manager dut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));
  timer_checker chk (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp),
                     .errors(errors), .pending(pending));

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    cmd.valid = 0; cmd.op = OP_TICK; cmd.timer_index = 0; cmd.now_time = 0;
    cmd.interval = 0; cmd.repeat_req = 0; cmd.user_tag = 0;
    rsp.ready = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result-side backpressure
  initial begin
    int n;
    rsp.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        rsp.ready = 0;
        for (int c = 0; c < 600; c++) @(negedge clk);
        hold_long = 0;
      end else if (stim_done || $urandom_range(0, 3) != 0) begin
        rsp.ready = 1;
        n = stim_done ? 0 : $urandom_range(0, 30);
        repeat (n) @(negedge clk);
        @(negedge clk);
      end else begin
        rsp.ready = 0;
        n = gap_len();
        repeat (n) @(negedge clk);
        @(negedge clk);
      end
    end
  end

  task automatic send(logic [1:0] op, logic [3:0] idx, logic [31:0] now,
                      logic [31:0] ivl, logic rep, logic [31:0] tag);
    @(negedge clk);
    cmd.valid = 1; cmd.op = op; cmd.timer_index = idx; cmd.now_time = now;
    cmd.interval = ivl; cmd.repeat_req = rep; cmd.user_tag = tag;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      cmd.valid = 0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    idle_gap(1);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic tick_to(logic [31:0] t);
    cur_time = t;
    send(OP_TICK, 0, t, 0, 0, 0);
  endtask

  initial begin
    int r;
    logic [31:0] ivl;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed
    send(OP_START, 0, cur_time, 0, 0, 32'h0);
    send(OP_START, 15, cur_time, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    send(OP_START, 0, cur_time, 5, 0, 32'h1234);
    send(OP_STOP, 3, cur_time, 0, 0, 0);
    send(OP_START, 3, cur_time, 10, 1, 32'hA5A5_5A5A);
    send(OP_START, 4, cur_time, 10, 0, 32'h5A5A_A5A5);
    send(OP_START, 5, cur_time, 0, 1, 32'hDEAD_BEEF);
    send(OP_START, 7, cur_time, 32'hFFFF_FFF0, 0, 32'h77);
    send(OP_STOP, 7, cur_time, 0, 0, 0);
    send(2'd3, 9, cur_time, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    tick_to(cur_time + 10);
    tick_to(cur_time + 10);
    send(OP_STOP, 3, cur_time, 0, 0, 0);
    send(OP_START, 8, 32'hFFFF_FFF0, 32'h40, 1, 32'h88);
    tick_to(32'hFFFF_FFFF);
    tick_to(32'h0000_0008);
    tick_to(32'h0000_0050);
    send(OP_STOP, 5, cur_time, 0, 0, 0);
    send(OP_STOP, 8, cur_time, 0, 0, 0);
    send(OP_STOP, 15, cur_time, 0, 0, 0);
    tick_to(32'h0000_0060);

    // random
    for (int i = 0; i < 260; i++) begin
      if (i == 60) begin
        for (int k = 0; k < 16; k++) send(OP_START, k, cur_time, 1, 1, $urandom());
        hold_long = 1;
        tick_to(cur_time + 2);
        tick_to(cur_time + 1);
      end
      if (i == 140) drain();
      r = $urandom_range(0, 99);
      if (r < 42) begin
        case ($urandom_range(0, 9))
          0: ivl = $urandom();
          1: ivl = 0;
          default: ivl = $urandom_range(0, 120);
        endcase
        send(OP_START, $urandom_range(0, 15), cur_time, ivl, $urandom_range(0, 1),
             $urandom());
      end else if (r < 60) begin
        send(OP_STOP, $urandom_range(0, 15), $urandom(), $urandom(), $urandom_range(0, 1),
             $urandom());
      end else if (r < 95) begin
        case ($urandom_range(0, 19))
          0: tick_to($urandom());
          1: tick_to(32'hFFFF_FFFF - $urandom_range(0, 60));
          default: tick_to(cur_time + $urandom_range(0, 60));
        endcase
      end else begin
        send(2'd3, $urandom_range(0, 15), $urandom(), $urandom(), $urandom_range(0, 1),
             $urandom());
      end
      idle_gap(gap_len());
    end
    drain();
    stim_done = 1;
    repeat (3000) @(posedge clk);
    if (errors == 0) begin
      $display("PASS multi_timer_expiry_manager");
    end else begin
      $display("FAIL multi_timer_expiry_manager");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL multi_timer_expiry_manager");
    $finish;
  end
endmodule
